[rtl/rgb_to_hsv_convert_unit_assert.svh]
// Assertion macros used by the converter's top-level RTL file.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`else

`define RHC_ASSERT_NOW(lbl, ante, cons)

`define RHC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/rhc_pkg.sv]
package rhc_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 17;

  // Hue sector numerator before scaling: t is at most 6 * 255.
  localparam int SECT_W = 11;
  // 60 * t fits in 17 bits.
  localparam int HNUM_W = 17;

  localparam int HUE_SECTOR_DEG = 60;

  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] delta;
  } rhc_side_t;

  typedef struct packed {
    rhc_side_t         side;
    logic [SECT_W-1:0] sect;
  } rhc_front_t;

endpackage

[rtl/rhc_if.sv]
interface rhc_pix_if;
  import rhc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_res_if;
  import rhc_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_q;
  logic [SAT_W-1:0]  sat_q;
  logic [CHAN_W-1:0] value_out;

  modport source (output valid, output hue_q, output sat_q, output value_out, input ready);
  modport sink   (input valid, input hue_q, input sat_q, input value_out, output ready);
endinterface

[rtl/rgb_to_hsv_convert_unit.sv]
// A front register feeds the two restoring dividers, at most DIV_STEPS quotient bits
//   per stage, with NW = max(8 + SAT_FRAC_BITS, 17 + HUE_FRAC_BITS) numerator bits.
// Throughput: one pixel per clock while res_o.ready is high.
// Every stage is a register with its own valid; depth is set by the dividers.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
`include "rgb_to_hsv_convert_unit_assert.svh"

module rgb_to_hsv_convert_unit #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16,
  parameter int DIV_STEPS     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhc_pix_if.sink    pix_i,
  rhc_res_if.source  res_o
);
  import rhc_pkg::*;

  // Both dividers share one numerator width so they line up stage for stage.
  localparam int SAT_NW = CHAN_W + SAT_FRAC_BITS;
  localparam int HUE_NW = HNUM_W + HUE_FRAC_BITS;
  localparam int NW     = (SAT_NW > HUE_NW) ? SAT_NW : HUE_NW;
  localparam int WW     = NW + CHAN_W;
  localparam int NSTG   = (NW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DEPTH  = NSTG + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // The front stage finds the maximum, delta and the hue sector numerator.
  logic       front_valid;
  rhc_front_t front;

  // Boundary k feeds divider stage k; boundary NSTG is the result register.
  logic          stg_valid [NSTG+1];
  logic          stg_ready [NSTG+1];
  rhc_side_t     stg_side  [NSTG+1];
  logic [WW-1:0] stg_wsat  [NSTG+1];
  logic [WW-1:0] stg_whue  [NSTG+1];

  logic [HNUM_W-1:0] hue_num;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (front_valid),
    .ready_i (stg_ready[0]),
    .front_o (front)
  );

  // Hue numerator is 60 times the sector value, scaled by the fraction bits;
  // the saturation numerator is delta scaled likewise. Remainders start at zero.
  assign hue_num      = HNUM_W'(front.sect) * HNUM_W'(HUE_SECTOR_DEG);
  assign stg_valid[0] = front_valid;
  assign stg_side[0]  = front.side;
  assign stg_wsat[0]  = {{CHAN_W{1'b0}}, NW'(front.side.delta) << SAT_FRAC_BITS};
  assign stg_whue[0]  = {{CHAN_W{1'b0}}, NW'(hue_num) << HUE_FRAC_BITS};

  for (genvar s = 0; s < NSTG; s++) begin : g_div
    localparam int LEFT    = NW - s * DIV_STEPS;
    localparam int STEPS_S = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

    rhc_div_stage #(
      .NW    (NW),
      .STEPS (STEPS_S)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[s]),
      .ready_o (stg_ready[s]),
      .side_i  (stg_side[s]),
      .wsat_i  (stg_wsat[s]),
      .whue_i  (stg_whue[s]),
      .valid_o (stg_valid[s+1]),
      .ready_i (stg_ready[s+1]),
      .side_o  (stg_side[s+1]),
      .wsat_o  (stg_wsat[s+1]),
      .whue_o  (stg_whue[s+1])
    );
  end

  // A grey pixel divides by zero in the hue lane; its hue and saturation are
  // forced to zero here. Quotients are cut to the field widths.
  logic grey;

  assign grey             = (stg_side[NSTG].delta == '0);
  assign stg_ready[NSTG]  = res_o.ready;
  assign res_o.valid      = stg_valid[NSTG];
  assign res_o.value_out  = stg_side[NSTG].mx;
  assign res_o.hue_q      = grey ? '0 : stg_whue[NSTG][HUE_W-1:0];
  assign res_o.sat_q      = grey ? '0 : stg_wsat[NSTG][SAT_W-1:0];

  // Number of requests inside the pipeline, for the checks below.
  logic [CNT_W-1:0] inflight_d, inflight_q;
  logic             pix_take, res_take;

  assign pix_take = pix_i.valid && pix_i.ready;
  assign res_take = res_o.valid && res_o.ready;

  always_comb begin
    inflight_d = inflight_q;
    if (pix_take && !res_take) begin
      inflight_d = inflight_q + CNT_W'(1);
    end else if (!pix_take && res_take) begin
      inflight_d = inflight_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // The pipeline never holds more requests than it has stages.
  `RHC_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_q <= CNT_W'(DEPTH))
  // A result can only be shown while some request is inside.
  `RHC_ASSERT_NOW(a_result_has_source, res_o.valid, inflight_q != '0)
  // Input backpressure only arises from a stalled result.
  `RHC_ASSERT_NOW(a_stall_origin, !pix_i.ready, res_o.valid && !res_o.ready)
  // A black pixel has no hue and no saturation.
  `RHC_ASSERT_NOW(a_black_pixel, res_o.valid && (res_o.value_out == '0),
                  (res_o.hue_q == '0) && (res_o.sat_q == '0))

endmodule

[rtl/rhc_front.sv]
module rhc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [rhc_pkg::CHAN_W-1:0]  red_i,
  input  logic [rhc_pkg::CHAN_W-1:0]  green_i,
  input  logic [rhc_pkg::CHAN_W-1:0]  blue_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output rhc_pkg::rhc_front_t         front_o
);
  import rhc_pkg::*;

  logic              valid_q;
  rhc_front_t        front_d, front_q;
  logic              red_top, green_top;
  logic [CHAN_W-1:0] mx, mn;
  logic [SECT_W-1:0] r_w, g_w, b_w, d_w;

  // Red wins a tie for the maximum, then green.
  always_comb begin
    red_top   = (red_i >= green_i) && (red_i >= blue_i);
    green_top = !red_top && (green_i >= blue_i);
    if (red_top) begin
      mx = red_i;
    end else if (green_top) begin
      mx = green_i;
    end else begin
      mx = blue_i;
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    r_w = SECT_W'(red_i);
    g_w = SECT_W'(green_i);
    b_w = SECT_W'(blue_i);
    d_w = SECT_W'(mx - mn);

    front_d.side.mx    = mx;
    front_d.side.delta = mx - mn;
    // Sector numerator in units of delta-sixths; always nonnegative and below 2^11.
    if (red_top) begin
      front_d.sect = (g_w - b_w) + ((green_i < blue_i) ? SECT_W'(6) * d_w : '0);
    end else if (green_top) begin
      front_d.sect = (b_w - r_w) + SECT_W'(2) * d_w;
    end else begin
      front_d.sect = (r_w - g_w) + SECT_W'(4) * d_w;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      front_q <= front_d;
    end
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

[rtl/rhc_div_stage.sv]
module rhc_div_stage #(
  parameter int NW    = 24,
  parameter int STEPS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  rhc_pkg::rhc_side_t              side_i,
  input  logic [NW+rhc_pkg::CHAN_W-1:0]   wsat_i,
  input  logic [NW+rhc_pkg::CHAN_W-1:0]   whue_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output rhc_pkg::rhc_side_t              side_o,
  output logic [NW+rhc_pkg::CHAN_W-1:0]   wsat_o,
  output logic [NW+rhc_pkg::CHAN_W-1:0]   whue_o
);
  import rhc_pkg::*;

  localparam int WW = NW + CHAN_W;

  logic          valid_q;
  rhc_side_t     side_q;
  logic [WW-1:0] wsat_d, wsat_q, whue_d, whue_q;

  // Each word holds the partial remainder on top and the numerator bits not
  // yet consumed below; quotient bits shift in at the bottom.
  always_comb begin
    logic [CHAN_W-1:0] rs, rh;
    logic [NW-1:0]     ns, nh;
    logic [CHAN_W:0]   ps, ph;
    rs = wsat_i[WW-1:NW];
    ns = wsat_i[NW-1:0];
    rh = whue_i[WW-1:NW];
    nh = whue_i[NW-1:0];
    for (int i = 0; i < STEPS; i++) begin
      ps = {rs, ns[NW-1]};
      ph = {rh, nh[NW-1]};
      if (ps >= {1'b0, side_i.mx}) begin
        rs = CHAN_W'(ps - {1'b0, side_i.mx});
        ns = {ns[NW-2:0], 1'b1};
      end else begin
        rs = ps[CHAN_W-1:0];
        ns = {ns[NW-2:0], 1'b0};
      end
      if (ph >= {1'b0, side_i.delta}) begin
        rh = CHAN_W'(ph - {1'b0, side_i.delta});
        nh = {nh[NW-2:0], 1'b1};
      end else begin
        rh = ph[CHAN_W-1:0];
        nh = {nh[NW-2:0], 1'b0};
      end
    end
    wsat_d = {rs, ns};
    whue_d = {rh, nh};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      side_q <= side_i;
      wsat_q <= wsat_d;
      whue_q <= whue_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign wsat_o  = wsat_q;
  assign whue_o  = whue_q;

endmodule
